[rtl/wcfs_pkg.sv]
package wcfs_pkg;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned ASG_W   = 64;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned SCORE_W = WGT_W + 1;
  localparam int unsigned S_DATA_W = 80;  // 73 payload bits padded to bytes
  localparam int unsigned M_DATA_W = 24;  // 20 payload bits padded to bytes

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_EVAL   = 2'd2,
    MODE_FLIP   = 2'd3
  } mode_e;

  // One item as it travels down the row of literal cells.
  typedef struct packed {
    logic             valid;
    mode_e            mode;
    logic [IDX_W-1:0] idx;
    logic             pol;
    logic [ASG_W-1:0] asg;   // assignment, bits at or above the variable count cleared
    logic             full;  // append found the store full at entry
    logic             acc;   // OR of hits seen so far
  } item_t;

endpackage

[rtl/weighted_clause_flip_scorer.sv]
// Channel    | Dir | Handshake                    | Content
// s_axis     | in  | s_axis_tvalid/s_axis_tready  | mode, var_index, positive, assignment
// m_axis     | out | m_axis_tvalid/m_axis_tready  | found, satisfied, flip_score, store_full
// cfg        | in  | cfg_valid_i/cfg_ready_o      | clause_weight
//
// Each item walks a row of MAX_LITERALS cells, one cell per cycle unless the output
// stalls, then an output register; one item is accepted per cycle while not stalled.
// The row length sets the latency; every cell holds one literal slot.
// Reset clears the literal count, the satisfied bit, the weight and all valids.
// A stalled output beat freezes the whole row, and s_axis_tready drops with it.
module weighted_clause_flip_scorer
  import wcfs_pkg::*;
#(
  parameter int unsigned MAX_LITERALS = 16,
  parameter int unsigned NUM_VARS     = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tdata: [1:0] mode, [7:2] var_index, [8] positive, [72:9] assignment, rest zero
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // tdata: [0] found, [1] satisfied, [18:2] flip_score, [19] store_full, rest zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [WGT_W-1:0]    cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_LITERALS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LITERALS);
  // Variables at or above NUM_VARS read as zero.
  localparam logic [ASG_W-1:0] ASG_MASK = {ASG_W{1'b1}} >> (ASG_W - NUM_VARS);

  logic adv, in_acc;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WGT_W-1:0] weight_q;
  logic             sat_q, sat_d;

  item_t            head;
  item_t            chain_item [MAX_LITERALS+1];
  logic [CNT_W-1:0] chain_cnt  [MAX_LITERALS+1];

  logic               out_valid_q;
  logic               found_q, found_d;
  logic               satisf_q;
  logic [SCORE_W-1:0] score_q, score_d;
  logic               full_q, full_d;
  item_t              tail;
  logic [SCORE_W-1:0] w_ext;

  // Advance everything when the output register is free or being drained.
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;
  assign cfg_ready_o   = 1'b1;

  // Build the entering beat; the append slot is the count at entry.
  always_comb begin
    head.valid = s_axis_tvalid;
    head.mode  = mode_e'(s_axis_tdata[1:0]);
    head.idx   = s_axis_tdata[7:2];
    head.pol   = s_axis_tdata[8];
    head.asg   = s_axis_tdata[72:9] & ASG_MASK;
    head.full  = (cnt_q == CNT_MAX);
    head.acc   = 1'b0;
    cnt_d      = cnt_q;
    if (in_acc && (head.mode == MODE_APPEND) && !head.full) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  assign chain_item[0] = head;
  assign chain_cnt[0]  = cnt_q;

  for (genvar k = 0; k < MAX_LITERALS; k++) begin : g_cell
    wcfs_cell #(
      .CNT_W (CNT_W),
      .POS   (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .item_i (chain_item[k]),
      .cnt_i  (chain_cnt[k]),
      .item_o (chain_item[k+1]),
      .cnt_o  (chain_cnt[k+1])
    );
  end

  assign tail  = chain_item[MAX_LITERALS];
  assign w_ext = {1'b0, weight_q};

  // Resolve the beat leaving the row: the accumulated OR is the query hit or
  // the clause value (after the flip, in flip mode).
  always_comb begin
    found_d = 1'b0;
    full_d  = 1'b0;
    score_d = '0;
    sat_d   = sat_q;
    unique case (tail.mode)
      MODE_APPEND: full_d  = tail.full;
      MODE_QUERY:  found_d = tail.acc;
      MODE_EVAL:   sat_d   = tail.acc;
      MODE_FLIP:   score_d = (sat_q ? '0 : w_ext) - (tail.acc ? '0 : w_ext);
      default:     sat_d   = sat_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      weight_q    <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_valid_i) begin
        weight_q <= cfg_data_i;
      end
      if (adv) begin
        out_valid_q <= tail.valid;
        if (tail.valid) begin
          sat_q <= sat_d;
        end
      end
    end
  end

  // Hold the result beat until taken.
  always_ff @(posedge clk_i) begin
    if (adv && tail.valid) begin
      found_q  <= found_d;
      satisf_q <= sat_d;
      score_q  <= score_d;
      full_q   <= full_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, full_q, score_q, satisf_q, found_q};

endmodule

[rtl/wcfs_cell.sv]
module wcfs_cell
  import wcfs_pkg::*;
#(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned POS   = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  item_t            item_i,
  input  logic [CNT_W-1:0] cnt_i,
  output item_t            item_o,
  output logic [CNT_W-1:0] cnt_o
);

  localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);

  logic [IDX_W-1:0] lit_idx_q;
  logic             lit_pol_q;
  item_t            item_q, item_d;
  logic [CNT_W-1:0] cnt_q;

  logic wr_en, occupied, var_val, lit_true, match, hit;

  assign wr_en = adv_i && item_i.valid && (item_i.mode == MODE_APPEND) &&
                 !item_i.full && (cnt_i == POS_C);

  // Only slots below the item's count hold a literal.
  assign occupied = cnt_i > POS_C;

  always_comb begin
    var_val  = item_i.asg[lit_idx_q] ^
               ((item_i.mode == MODE_FLIP) && (lit_idx_q == item_i.idx));
    lit_true = lit_pol_q ? var_val : !var_val;
    match    = (lit_idx_q == item_i.idx) && (lit_pol_q == item_i.pol);
    hit      = (item_i.mode == MODE_QUERY) ? match : lit_true;
    item_d     = item_i;
    item_d.acc = item_i.acc ||
                 (occupied && hit && (item_i.mode != MODE_APPEND));
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      lit_idx_q <= item_i.idx;
      lit_pol_q <= item_i.pol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
      cnt_q  <= '0;
    end else if (adv_i) begin
      item_q <= item_d;
      cnt_q  <= cnt_i;
    end
  end

  assign item_o = item_q;
  assign cnt_o  = cnt_q;

endmodule
